// ===== rtl/handshake_hello_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// Handshake hello parser assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_HELLO_PARSER_TOP_ASSERT_SVH
`define HANDSHAKE_HELLO_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hhp assertion failed");
// Check that ante implies cons in the same cycle.
`define HHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hhp implication failed");
// Check that ante implies cons in the next cycle.
`define HHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hhp next-cycle implication failed");
`else
`define HHP_ASSERT(lbl, prop)
`define HHP_ASSERT_IMP(lbl, ante, cons)
`define HHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/hhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Handshake hello parser package
// Shared constants, status codes, configuration types and peer matching.
// ----------------------------------------------------------------------------
package hhp_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int HdrCntW      = $clog2(HEADER_BYTES);

  localparam logic [15:0] MinBody = 16'd3;
  localparam logic [15:0] MaxBody = 16'd258;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOCAL_TYPE = 3'd0;
  localparam logic [2:0] CFG_MAGIC      = 3'd1;
  localparam logic [2:0] CFG_VERSION    = 3'd2;
  localparam logic [2:0] CFG_FLAGS      = 3'd3;
  localparam logic [2:0] CFG_HELLO      = 3'd4;

  // Socket types
  localparam logic [7:0] SOCK_PAIR   = 8'd0;
  localparam logic [7:0] SOCK_PUB    = 8'd1;
  localparam logic [7:0] SOCK_SUB    = 8'd2;
  localparam logic [7:0] SOCK_DEALER = 8'd5;
  localparam logic [7:0] SOCK_ROUTER = 8'd6;
  localparam logic [7:0] SOCK_XPUB   = 8'd9;
  localparam logic [7:0] SOCK_XSUB   = 8'd10;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_BAD_FLAGS = 3'd4,
    ST_BAD_CODE  = 3'd5,
    ST_BAD_PEER  = 3'd6,
    ST_BAD_IDLEN = 3'd7
  } status_e;

  typedef struct packed {
    logic [3:0] local_type;
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] flags;
    logic [7:0] hello;
  } cfg_t;

  // Fixed header bytes and the body head as seen when the body ends
  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] flags;
    logic [7:0] reserved;
    logic [7:0] code;
    logic [7:0] peer;
    logic [7:0] id_len;
    logic [8:0] body_size;
  } frame_t;

  function automatic logic peer_ok(logic [3:0] local_type, logic [7:0] peer);
    logic [7:0] lt;
    logic       ok;
    lt = {4'b0, local_type};
    ok = 1'b0;
    if (lt == SOCK_DEALER || lt == SOCK_ROUTER) begin
      ok = (peer == SOCK_DEALER) || (peer == SOCK_ROUTER);
    end else if (lt == SOCK_PUB || lt == SOCK_XPUB) begin
      ok = (peer == SOCK_SUB) || (peer == SOCK_XSUB);
    end else if (lt == SOCK_SUB || lt == SOCK_XSUB) begin
      ok = (peer == SOCK_PUB) || (peer == SOCK_XPUB);
    end else if (lt == SOCK_PAIR) begin
      ok = (peer == SOCK_PAIR);
    end
    return ok;
  endfunction

endpackage

// ===== rtl/hhp_judge.sv =====
// ----------------------------------------------------------------------------
// Handshake hello parser final check
// Ranks the end-of-body checks and returns the first failure or success.
// ----------------------------------------------------------------------------
module hhp_judge import hhp_pkg::*; (
  input  cfg_t    cfg_i,
  input  frame_t  frame_i,
  output status_e status_o
);

  logic [8:0] want_len;

  assign want_len = 9'd3 + {1'b0, frame_i.id_len};

  always_comb begin
    priority if (frame_i.magic != cfg_i.magic || frame_i.version != cfg_i.version) begin
      status_o = ST_BAD_MAGIC;
    end else if (frame_i.reserved != 8'd0 || frame_i.flags != cfg_i.flags) begin
      status_o = ST_BAD_FLAGS;
    end else if (frame_i.code != cfg_i.hello) begin
      status_o = ST_BAD_CODE;
    end else if (!peer_ok(cfg_i.local_type, frame_i.peer)) begin
      status_o = ST_BAD_PEER;
    end else if (frame_i.body_size != want_len) begin
      status_o = ST_BAD_IDLEN;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// ===== rtl/handshake_hello_parser_top.sv =====
// ----------------------------------------------------------------------------
// Handshake hello parser, top level
// Takes one handshake byte per word, returns one status word per byte.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock when the output is not stalled; each
// byte yields exactly one result word. A byte first lands in an input
// register, and the header/body counters, the length check and the final
// check all run in the single cycle that moves it into the result register.
// The input register lets one more byte in while a result waits on the
// output. Status stays busy until the byte that ends the parse, then holds
// its value until reset; later bytes are ignored.
// Configuration may be written only while the parser is idle.
`include "handshake_hello_parser_top_assert.svh"

module handshake_hello_parser_top import hhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic       identity_valid_o,
  output logic [7:0] identity_byte_o,
  output logic [7:0] peer_sock_o,
  output logic [7:0] identity_length_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  cfg_t cfg_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;
  logic       fire;

  phase_e               phase_q, phase_d;
  logic [HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [8:0]           body_cnt_q, body_cnt_d;
  logic [15:0]          len_lo_q, len_lo_d;
  logic                 len_hi_q, len_hi_d;
  logic [7:0]           hdr_store_q [4];
  logic [7:0]           body_head_q [3];
  logic [7:0]           body_head_d [3];
  status_e              final_q, final_d;
  logic                 idv_q, idv_d;
  logic [7:0]           idb_q, idb_d;

  logic [4:0]           hdr_cnt_ext;
  logic                 hdr_last;
  logic                 len_bad;
  frame_t               frame;
  status_e              judge_status;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL_TYPE: cfg_q.local_type <= cfg_wdata_i[3:0];
        CFG_MAGIC:      cfg_q.magic      <= cfg_wdata_i;
        CFG_VERSION:    cfg_q.version    <= cfg_wdata_i;
        CFG_FLAGS:      cfg_q.flags      <= cfg_wdata_i;
        CFG_HELLO:      cfg_q.hello      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register refills whenever its word moves on
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Parse step
  assign hdr_cnt_ext = 5'(hdr_cnt_q);
  assign hdr_last    = (hdr_cnt_q == HdrCntW'(HEADER_BYTES - 1));

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    body_cnt_d  = body_cnt_q;
    len_lo_d    = len_lo_q;
    len_hi_d    = len_hi_q;
    body_head_d = body_head_q;
    final_d     = final_q;
    idv_d       = 1'b0;
    idb_d       = 8'd0;
    unique case (phase_q)
      PH_HEADER: begin
        if (hdr_cnt_ext >= 5'd4 && hdr_cnt_ext < 5'd8) begin
          len_hi_d = len_hi_q || (len_lo_q[15:8] != 8'd0);
          len_lo_d = {len_lo_q[7:0], in_byte_q};
        end
        if (hdr_last) begin
          hdr_cnt_d = '0;
          if (len_bad) begin
            final_d = ST_BAD_LEN;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_BODY;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
        end
      end
      PH_BODY: begin
        if (body_cnt_q < 9'd3) begin
          body_head_d[body_cnt_q[1:0]] = in_byte_q;
        end else begin
          idv_d = 1'b1;
          idb_d = in_byte_q;
        end
        body_cnt_d = body_cnt_q + 9'd1;
        // Length is at most 258 here, so the low nine bits carry it
        if (body_cnt_d >= len_lo_q[8:0]) begin
          final_d = judge_status;
          phase_d = PH_DONE;
        end
      end
      PH_DONE: ;
      default: phase_d = PH_DONE;
    endcase
  end

  assign len_bad = len_hi_d || (len_lo_d < MinBody) || (len_lo_d > MaxBody);

  assign frame = '{
    magic:     hdr_store_q[0],
    version:   hdr_store_q[1],
    flags:     hdr_store_q[2],
    reserved:  hdr_store_q[3],
    code:      body_head_d[0],
    peer:      body_head_d[1],
    id_len:    body_head_d[2],
    body_size: len_lo_q[8:0]
  };

  hhp_judge u_judge (
    .cfg_i    (cfg_q),
    .frame_i  (frame),
    .status_o (judge_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      body_cnt_q  <= '0;
      len_lo_q    <= '0;
      len_hi_q    <= 1'b0;
      body_head_q <= '{default: 8'd0};
      final_q     <= ST_BUSY;
      idv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        body_cnt_q  <= body_cnt_d;
        len_lo_q    <= len_lo_d;
        len_hi_q    <= len_hi_d;
        body_head_q <= body_head_d;
        final_q     <= final_d;
        idv_q       <= idv_d;
      end
    end
  end

  // Header store and identity byte carry no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      idb_q <= idb_d;
      if (phase_q == PH_HEADER && hdr_cnt_ext < 5'd4) begin
        hdr_store_q[hdr_cnt_q[1:0]] <= in_byte_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = final_q;
  assign identity_valid_o  = idv_q;
  assign identity_byte_o   = idb_q;
  assign peer_sock_o       = body_head_q[1];
  assign identity_length_o = body_head_q[2];

  `HHP_ASSERT_IMP(a_done_has_status, phase_q == PH_DONE, final_q != ST_BUSY)
  `HHP_ASSERT_NEXT(a_done_holds, phase_q == PH_DONE, phase_q == PH_DONE && $stable(final_q))
  `HHP_ASSERT_IMP(a_id_after_head, idv_q, body_cnt_q >= 9'd4)
  `HHP_ASSERT_IMP(a_ready_when_empty, !out_valid_q, in_ready_o)
  `HHP_ASSERT(a_body_len_fits, phase_q != PH_BODY || (!len_hi_q && len_lo_q <= MaxBody))

endmodule
